// File: rtl/tacn_pkg.sv
// ----------------------------------------------------------------------------
// Tile average color to note: shared package
// Payload types, geometry limits and the control and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tacn_pkg;

    // Geometry limits.
    localparam int MAX_TILE_COLS = 64;
    localparam int MAX_TILE_SIZE = 64;
    localparam int MAX_DIM       = 4096;

    // Address bits of the tile sum store.
    localparam int TC_AW = $clog2(MAX_TILE_COLS);

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_SIZE    = 2'd2;

    // One input pixel.
    typedef struct packed {
        logic [7:0] chan_0;
        logic [7:0] chan_1;
        logic [7:0] chan_2;
        logic       frame_start;
    } t_in;

    // One finished tile.
    typedef struct packed {
        logic [5:0]  tile_col;
        logic [11:0] tile_row;
        logic [6:0]  note;
        logic        last_tile;
    } t_out;

    // Clamped geometry as seen by the datapath.
    typedef struct packed {
        logic [12:0] w;
        logic [12:0] h;
        logic [6:0]  ts;
    } t_geom;

    // Commands from the controller.
    typedef struct packed {
        logic accept;
        logic sync_start;
        logic sync_step;
        logic upd;
        logic sel;
        logic mul;
        logic add;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        logic emit;
        logic cnt_zero;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/tile_average_color_to_note_core.sv
// ----------------------------------------------------------------------------
// Tile average color to note: top level
// Pixels in raster order in, one note per full tile out.
// ----------------------------------------------------------------------------
// The block takes one pixel at a time. A pixel that does not close a tile
// is accepted with a read of its tile column's sums from the 64-entry sum
// memory, and its updated sums are then written back. The bottom-right
// pixel of a full tile then passes channel compare, constant multiplies,
// one add and a 7-step shift-subtract divider for the note, and waits for
// a free output register to load its result. The next pixel may be taken
// while a result waits in the output register. After a tile_size write the
// block realigns its tile counters with a 12-step divider before it takes
// the next pixel. The sum memory needs no clearing after reset; the first
// pixel of each tile restarts its sums.
module tile_average_color_to_note_core
    import tacn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    // Tile result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_geom geom;
    logic  ts_wr;
    t_cmd  cmd;
    t_sts  sts;

    // Configuration registers.
    tacn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom),
        .o_ts_wr (ts_wr)
    );

    // Sequencing.
    tacn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_ts_wr    (ts_wr),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Counters, sums and note arithmetic.
    tacn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_geom      (geom),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // One pixel at a time: the cycle after a transaction the input stalls.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken on two consecutive cycles");

    // A tile size write forces realignment before the next pixel.
    a_resync_after_ts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[3:2] == REG_TILE_SIZE)) |=> o_in_stall)
        else $error("pixel taken before tile counters were realigned");

    // A result can only be loaded while the block is busy with a pixel.
    a_result_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a pixel in flight");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

// File: rtl/tacn_cfg.sv
// ----------------------------------------------------------------------------
// Tile average color to note: configuration registers
// APB-style register file holding image width, image height and tile size,
// with the range clamping that the datapath expects.
// ----------------------------------------------------------------------------
module tacn_cfg
    import tacn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_geom       o_geom,
    output logic        o_ts_wr
);

    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [6:0]  r_tsize;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd640;
            r_height <= 13'd480;
            r_tsize  <= 7'd16;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:  r_width  <= pwdata[12:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[12:0];
                REG_TILE_SIZE:    r_tsize  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // A tile size change calls for a realignment of the position counters.
    assign o_ts_wr = wr_en && (paddr[3:2] == REG_TILE_SIZE);

    // Register reads.
    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = {19'd0, r_width};
            REG_IMAGE_HEIGHT: prdata = {19'd0, r_height};
            REG_TILE_SIZE:    prdata = {25'd0, r_tsize};
            default:          prdata = 32'd0;
        endcase
    end

    // Clamp the registers into their usable ranges.
    always_comb begin
        if (r_width == 13'd0)                o_geom.w = 13'd1;
        else if (r_width > 13'(MAX_DIM))     o_geom.w = 13'(MAX_DIM);
        else                                 o_geom.w = r_width;

        if (r_height == 13'd0)               o_geom.h = 13'd1;
        else if (r_height > 13'(MAX_DIM))    o_geom.h = 13'(MAX_DIM);
        else                                 o_geom.h = r_height;

        if (r_tsize == 7'd0)                 o_geom.ts = 7'd1;
        else if (r_tsize > 7'(MAX_TILE_SIZE)) o_geom.ts = 7'(MAX_TILE_SIZE);
        else                                 o_geom.ts = r_tsize;
    end

endmodule

// File: rtl/tacn_ctrl.sv
// ----------------------------------------------------------------------------
// Tile average color to note: controller
// Sequences one pixel at a time through sum update, note arithmetic, the
// shift-subtract divider and the output register. Also runs the
// position realignment after a tile size change.
// ----------------------------------------------------------------------------
module tacn_ctrl
    import tacn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_ts_wr,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SYNC,
        S_UPD,
        S_SEL,
        S_MUL,
        S_ADD,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_resync;
    logic   n_resync;
    logic   ready;

    assign ready      = (r_state == S_IDLE) && !r_resync;
    assign o_in_stall = !ready;

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        n_resync = r_resync;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (r_resync) begin
                    o_cmd.sync_start = 1'b1;
                    n_state          = S_SYNC;
                end else if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_UPD;
                end
            end
            S_SYNC: begin
                o_cmd.sync_step = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_resync = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.emit ? S_SEL : S_IDLE;
            end
            S_SEL: begin
                o_cmd.sel = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // A tile size write always forces a realignment.
        if (i_ts_wr) begin
            n_resync = 1'b1;
        end
    end

    // State and the realignment flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_resync <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resync <= n_resync;
        end
    end

endmodule

// File: rtl/tacn_dp.sv
// ----------------------------------------------------------------------------
// Tile average color to note: datapath
// Position counters, the tile sum store, the note arithmetic with its
// shift-subtract divider, the position realignment divider and the output
// register.
// ----------------------------------------------------------------------------
module tacn_dp
    import tacn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_geom i_geom,
    input  t_in   i_in_data,
    input  logic  i_out_stall,
    output t_sts  o_sts,
    output logic  o_out_valid,
    output t_out  o_out_data
);

    // Products of the scaled color constants with 17.46.
    localparam logic [23:0] KC_CHAN0 = 24'd10242036;  // 5866 * 1746
    localparam logic [23:0] KC_CHAN1 = 24'd5121018;   // 2933 * 1746
    localparam logic [23:0] KC_NONE  = 24'd0;

    // Position of the next pixel.
    logic [11:0] r_x, r_y, r_tc, r_tr;
    logic [5:0]  r_ox, r_oy;

    // Position of the arriving pixel.
    logic [11:0] cur_x, cur_y, cur_tc, cur_tr;
    logic [5:0]  cur_ox, cur_oy;

    // Tile geometry checks.
    logic [11:0] tile_x0, tile_y0;
    logic [13:0] end_x, end_y, end2_x, end2_y;
    logic        fits, first_pix, last_pix, last_col, last_row;
    logic [12:0] nx, ny;

    // Latched pixel and its tile.
    logic [7:0]      r_px0, r_px1, r_px2;
    logic [TC_AW-1:0] r_addr;
    logic            r_in_tile, r_first, r_lastpix, r_lastt;
    logic [11:0]     r_otc, r_otr;

    // Tile sum store.
    logic [59:0] r_mem [MAX_TILE_COLS];
    logic [59:0] r_rd;
    logic [19:0] new_s0, new_s1, new_s2;
    logic [19:0] r_s0, r_s1, r_s2;

    // Note arithmetic.
    logic [12:0] r_n;
    logic [21:0] r_t;
    logic [23:0] r_kc;
    logic [36:0] r_pa, r_pb, r_rem;
    logic [29:0] r_den;
    logic [6:0]  r_q;
    logic [36:0] den_sh;
    logic        den_ge;

    // Shared step counter and realignment divider.
    logic [3:0]  r_cnt;
    logic [11:0] r_rx, r_ry, r_qx, r_qy;
    logic [18:0] ts_sh;
    logic        gx, gy;
    logic [11:0] n_rx, n_ry, n_qx, n_qy;

    // Output register.
    logic r_ovalid;
    t_out r_odata;

    // A frame start puts the pixel at the origin.
    always_comb begin
        if (i_in_data.frame_start) begin
            cur_x  = '0; cur_y  = '0;
            cur_tc = '0; cur_tr = '0;
            cur_ox = '0; cur_oy = '0;
        end else begin
            cur_x  = r_x;  cur_y  = r_y;
            cur_tc = r_tc; cur_tr = r_tr;
            cur_ox = r_ox; cur_oy = r_oy;
        end
    end

    // Full-tile, first-pixel and last-pixel checks without any division.
    always_comb begin
        tile_x0   = cur_x - {6'd0, cur_ox};
        tile_y0   = cur_y - {6'd0, cur_oy};
        end_x     = {2'd0, tile_x0} + {7'd0, i_geom.ts};
        end_y     = {2'd0, tile_y0} + {7'd0, i_geom.ts};
        end2_x    = end_x + {7'd0, i_geom.ts};
        end2_y    = end_y + {7'd0, i_geom.ts};
        fits      = (end_x <= {1'b0, i_geom.w}) && (end_y <= {1'b0, i_geom.h})
                    && (cur_tc < 12'(MAX_TILE_COLS));
        first_pix = (cur_ox == 6'd0) && (cur_oy == 6'd0);
        last_pix  = ({1'b0, cur_ox} == i_geom.ts - 7'd1)
                    && ({1'b0, cur_oy} == i_geom.ts - 7'd1);
        last_col  = (end2_x > {1'b0, i_geom.w})
                    || (cur_tc == 12'(MAX_TILE_COLS - 1));
        last_row  = end2_y > {1'b0, i_geom.h};
        nx        = {1'b0, cur_x} + 13'd1;
        ny        = {1'b0, cur_y} + 13'd1;
    end

    // Realignment divider: one quotient bit of x / ts and y / ts per step.
    always_comb begin
        ts_sh = {12'd0, i_geom.ts} << r_cnt;
        gx    = {7'd0, r_rx} >= ts_sh;
        gy    = {7'd0, r_ry} >= ts_sh;
        n_rx  = gx ? r_rx - ts_sh[11:0] : r_rx;
        n_ry  = gy ? r_ry - ts_sh[11:0] : r_ry;
        n_qx  = r_qx;
        n_qy  = r_qy;
        n_qx[r_cnt] = gx;
        n_qy[r_cnt] = gy;
    end

    // Position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0; r_y  <= '0;
            r_tc <= '0; r_tr <= '0;
            r_ox <= '0; r_oy <= '0;
        end else if (i_cmd.accept) begin
            if (nx >= i_geom.w) begin
                r_x  <= '0;
                r_ox <= '0;
                r_tc <= '0;
                if (ny >= i_geom.h) begin
                    r_y  <= '0;
                    r_oy <= '0;
                    r_tr <= '0;
                end else begin
                    r_y <= ny[11:0];
                    if ({1'b0, cur_oy} + 7'd1 == i_geom.ts) begin
                        r_oy <= '0;
                        r_tr <= cur_tr + 12'd1;
                    end else begin
                        r_oy <= cur_oy + 6'd1;
                        r_tr <= cur_tr;
                    end
                end
            end else begin
                r_x  <= nx[11:0];
                r_y  <= cur_y;
                r_oy <= cur_oy;
                r_tr <= cur_tr;
                if ({1'b0, cur_ox} + 7'd1 == i_geom.ts) begin
                    r_ox <= '0;
                    r_tc <= cur_tc + 12'd1;
                end else begin
                    r_ox <= cur_ox + 6'd1;
                    r_tc <= cur_tc;
                end
            end
        end else if (i_cmd.sync_step && (r_cnt == 4'd0)) begin
            r_tc <= n_qx;
            r_tr <= n_qy;
            r_ox <= n_rx[5:0];
            r_oy <= n_ry[5:0];
        end
    end

    // Latch the pixel and its tile bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px0     <= i_in_data.chan_0;
            r_px1     <= i_in_data.chan_1;
            r_px2     <= i_in_data.chan_2;
            r_addr    <= cur_tc[TC_AW-1:0];
            r_first   <= first_pix;
            r_lastpix <= last_pix;
            r_lastt   <= last_col && last_row;
            r_otc     <= cur_tc;
            r_otr     <= cur_tr;
        end
    end

    // The in-tile flag steers the controller, so it is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tile <= 1'b0;
        end else if (i_cmd.accept) begin
            r_in_tile <= fits;
        end
    end

    // New sums: the first pixel of a tile restarts them.
    always_comb begin
        if (r_first) begin
            new_s0 = {12'd0, r_px0};
            new_s1 = {12'd0, r_px1};
            new_s2 = {12'd0, r_px2};
        end else begin
            new_s0 = r_rd[19:0]  + {12'd0, r_px0};
            new_s1 = r_rd[39:20] + {12'd0, r_px1};
            new_s2 = r_rd[59:40] + {12'd0, r_px2};
        end
    end

    // Tile sum store: read on acceptance, write back in the update cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[cur_tc[TC_AW-1:0]];
        end
        if (i_cmd.upd && r_in_tile) begin
            r_mem[r_addr] <= {new_s2, new_s1, new_s0};
        end
    end

    // Note arithmetic, one stage per command.
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_s0 <= new_s0;
            r_s1 <= new_s1;
            r_s2 <= new_s2;
            r_n  <= {6'd0, i_geom.ts} * {6'd0, i_geom.ts};
        end
        // Dominant channel picks the pair of sums and the hue offset.
        if (i_cmd.sel) begin
            if ((r_s0 > r_s1) && (r_s0 > r_s2)) begin
                r_t  <= {2'd0, r_s1} + {2'd0, r_s2} + {8'd0, r_n, 1'b0};
                r_kc <= KC_CHAN0;
            end else if ((r_s1 > r_s2) && (r_s1 > r_s0)) begin
                r_t  <= {2'd0, r_s2} + {2'd0, r_s0} + {8'd0, r_n, 1'b0};
                r_kc <= KC_CHAN1;
            end else begin
                r_t  <= {2'd0, r_s1} + {2'd0, r_s0} + {8'd0, r_n, 1'b0};
                r_kc <= KC_NONE;
            end
        end
        if (i_cmd.mul) begin
            r_pa  <= {15'd0, r_t} * 37'd10000;
            r_pb  <= {13'd0, r_kc} * {24'd0, r_n};
            r_den <= {17'd0, r_n} * 30'd174600;
        end
    end

    // Divider compare for the note quotient.
    always_comb begin
        den_sh = {7'd0, r_den} << r_cnt;
        den_ge = r_rem >= den_sh;
    end

    // Shared step counter, realignment divider and note divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sync_start) begin
            r_rx  <= r_x;
            r_ry  <= r_y;
            r_qx  <= '0;
            r_qy  <= '0;
            r_cnt <= 4'd11;
        end else if (i_cmd.sync_step) begin
            r_rx  <= n_rx;
            r_ry  <= n_ry;
            r_qx  <= n_qx;
            r_qy  <= n_qy;
            r_cnt <= r_cnt - 4'd1;
        end else if (i_cmd.add) begin
            r_rem <= r_pa + r_pb;
            r_q   <= '0;
            r_cnt <= 4'd6;
        end else if (i_cmd.div_step) begin
            if (den_ge) begin
                r_rem <= r_rem - den_sh;
            end
            r_q[r_cnt[2:0]] <= den_ge;
            r_cnt           <= r_cnt - 4'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata.tile_col  <= r_otc[5:0];
            r_odata.tile_row  <= r_otr;
            r_odata.note      <= r_q + 7'd1;
            r_odata.last_tile <= r_lastt;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_out_data     = r_odata;
    assign o_sts.emit     = r_in_tile && r_lastpix;
    assign o_sts.cnt_zero = (r_cnt == 4'd0);
    assign o_sts.out_free = !r_ovalid || !i_out_stall;

endmodule
